[design/thc_pkg.sv]
// Package: shared types, constants and helper functions for the heading core.
package thc_pkg;

  // Angle format and CORDIC depth
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 16;
  localparam int ATAN_LEN        = 24;
  localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int QA    = 30;
  localparam int SH    = QA - ANGLE_FRAC_BITS;

  // Q.30 angle constants and CORDIC gain compensation
  localparam longint PI_Q      = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint TWO_PI_Q  = 64'sd6746518852;
  localparam longint KGAIN_Q   = 64'sd652032874;

  // Datapath widths
  localparam int IN_W      = 16;
  localparam int SUM_W     = IN_W + 1;
  localparam int CW        = 33;
  localparam int RW        = 34;
  localparam int AW        = (SH + 17 > 35) ? SH + 17 : 35;
  localparam int HW        = AW + 1;
  localparam int VW        = 54;
  localparam int ZW        = 36;
  localparam int RND_W     = 72;
  localparam int FLD_QBITS = 23;
  localparam int FLD_W     = FLD_QBITS + 1;
  localparam int FLD_FRAC  = 12;
  localparam int NUM_W     = 30;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFS_X = 3'd0,
    CFG_OFS_Y = 3'd1,
    CFG_OFS_Z = 3'd2,
    CFG_GAIN  = 3'd3,
    CFG_DECL  = 3'd4
  } cfg_idx_t;

  // Transaction payloads
  typedef struct packed {
    logic                    mode;
    logic signed [IN_W-1:0]  raw_x;
    logic signed [IN_W-1:0]  raw_y;
    logic signed [IN_W-1:0]  raw_z;
    logic signed [IN_W-1:0]  pitch_angle;
    logic signed [IN_W-1:0]  roll_angle;
  } in_t;

  typedef struct packed {
    logic signed [FLD_W-1:0] field_x;
    logic signed [FLD_W-1:0] field_y;
    logic signed [FLD_W-1:0] field_z;
    logic signed [IN_W-1:0]  heading_angle;
  } out_t;

  // Offset-corrected sample that travels beside the angle pipeline
  typedef struct packed {
    logic                    mode;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
  } side_t;

  // Arctangent table, Q.30
  function automatic logic [29:0] atan_f(input int i);
    case (i)
      0:       atan_f = 30'd843314856;
      1:       atan_f = 30'd497837829;
      2:       atan_f = 30'd263043836;
      3:       atan_f = 30'd133525158;
      4:       atan_f = 30'd67021686;
      5:       atan_f = 30'd33543515;
      6:       atan_f = 30'd16775850;
      7:       atan_f = 30'd8388437;
      8:       atan_f = 30'd4194282;
      9:       atan_f = 30'd2097149;
      10:      atan_f = 30'd1048575;
      11:      atan_f = 30'd524287;
      12:      atan_f = 30'd262143;
      13:      atan_f = 30'd131071;
      14:      atan_f = 30'd65535;
      15:      atan_f = 30'd32767;
      16:      atan_f = 30'd16383;
      17:      atan_f = 30'd8191;
      18:      atan_f = 30'd4095;
      19:      atan_f = 30'd2047;
      20:      atan_f = 30'd1023;
      21:      atan_f = 30'd511;
      22:      atan_f = 30'd255;
      23:      atan_f = 30'd127;
      default: atan_f = 30'd0;
    endcase
  endfunction

  // Shift right by k, rounding half away from zero
  function automatic logic signed [RND_W-1:0] rnd_shift_f(input logic signed [RND_W-1:0] v,
                                                          input int k);
    logic signed [RND_W-1:0] half;
    if (k == 0) begin
      return v;
    end
    half = RND_W'(1) <<< (k - 1);
    if (v >= 0) begin
      return (v + half) >>> k;
    end
    return -((-v + half) >>> k);
  endfunction

  // Conditional 2*pi subtractions needed to reduce any input angle
  function automatic int mod_steps_f();
    longint lim;
    int     m;
    lim = 64'sd1 <<< (15 + SH);
    m   = 0;
    for (int k = 0; k < 8; k++) begin
      if ((TWO_PI_Q <<< m) <= lim) begin
        m++;
      end
    end
    return m;
  endfunction

  localparam int     MOD_STEPS = mod_steps_f();
  localparam longint PI_OUT    = 64'(rnd_shift_f(RND_W'(PI_Q), SH));

  // Pipeline latencies
  localparam int SC_LAT    = NSTEP + 3;
  localparam int TILT_LAT  = 4;
  localparam int VEC_LAT   = NSTEP + 3;
  localparam int HDG_LAT   = SC_LAT + TILT_LAT + VEC_LAT;
  localparam int DIV_LAT   = FLD_QBITS + 2;
  localparam int FLD_DLY   = HDG_LAT - DIV_LAT;
  localparam int TOTAL_LAT = HDG_LAT + 1;

endpackage

[design/thc_fld_div.sv]
// Pipelined restoring divider: divides the three offset-corrected axes by the gain.
module thc_fld_div import thc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic signed [SUM_W-1:0] in_sx,
  input  logic signed [SUM_W-1:0] in_sy,
  input  logic signed [SUM_W-1:0] in_sz,
  input  logic        [IN_W-1:0]  gain,
  output logic                    out_vld,
  output logic signed [FLD_W-1:0] out_fx,
  output logic signed [FLD_W-1:0] out_fy,
  output logic signed [FLD_W-1:0] out_fz
);

  logic        [IN_W-1:0]      g_eff;
  logic signed [SUM_W-1:0]     s_in    [3];
  logic        [SUM_W-1:0]     mag_nxt [3];
  logic        [NUM_W-1:0]     num_nxt [3];

  logic                        vld_r   [0:FLD_QBITS];
  logic        [NUM_W-1:0]     rem_r   [0:FLD_QBITS][3];
  logic        [FLD_QBITS-1:0] q_r     [0:FLD_QBITS][3];
  logic                        neg_r   [0:FLD_QBITS][3];
  logic                        sat_r   [0:FLD_QBITS][3];

  logic                        ovld_r;
  logic signed [FLD_W-1:0]     f_r     [3];

  assign g_eff   = (gain == '0) ? IN_W'(1) : gain;
  assign s_in[0] = in_sx;
  assign s_in[1] = in_sy;
  assign s_in[2] = in_sz;

  // Form the rounded numerator and flag quotients past the field range
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_nxt[l] = s_in[l][SUM_W-1] ? SUM_W'(-s_in[l]) : SUM_W'(s_in[l]);
      num_nxt[l] = NUM_W'({mag_nxt[l], {FLD_FRAC{1'b0}}}) + NUM_W'(g_eff >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    for (int l = 0; l < 3; l++) begin
      rem_r[0][l] <= num_nxt[l];
      q_r[0][l]   <= '0;
      neg_r[0][l] <= s_in[l][SUM_W-1];
      sat_r[0][l] <= (num_nxt[l] >> FLD_QBITS) >= NUM_W'(g_eff);
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < FLD_QBITS; j++) begin : g_div
    localparam int K = FLD_QBITS - 1 - j;
    logic [NUM_W+IN_W-1:0] dvs;
    assign dvs = (NUM_W+IN_W)'(g_eff) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
      for (int l = 0; l < 3; l++) begin
        neg_r[j+1][l] <= neg_r[j][l];
        sat_r[j+1][l] <= sat_r[j][l];
        if ((NUM_W+IN_W)'(rem_r[j][l]) >= dvs) begin
          rem_r[j+1][l] <= rem_r[j][l] - dvs[NUM_W-1:0];
          q_r[j+1][l]   <= q_r[j][l] | (FLD_QBITS'(1) << K);
        end else begin
          rem_r[j+1][l] <= rem_r[j][l];
          q_r[j+1][l]   <= q_r[j][l];
        end
      end
    end
  end

  // Apply sign and saturate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r[FLD_QBITS];
    end
    for (int l = 0; l < 3; l++) begin
      if (sat_r[FLD_QBITS][l]) begin
        f_r[l] <= neg_r[FLD_QBITS][l] ? {1'b1, {FLD_QBITS{1'b0}}} : {1'b0, {FLD_QBITS{1'b1}}};
      end else if (neg_r[FLD_QBITS][l]) begin
        f_r[l] <= -$signed({1'b0, q_r[FLD_QBITS][l]});
      end else begin
        f_r[l] <= $signed({1'b0, q_r[FLD_QBITS][l]});
      end
    end
  end

  assign out_vld = ovld_r;
  assign out_fx  = f_r[0];
  assign out_fy  = f_r[1];
  assign out_fz  = f_r[2];

endmodule

[design/thc_sincos.sv]
// Two-lane pipelined CORDIC rotation: sin and cos of pitch and roll.
module thc_sincos import thc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic signed [IN_W-1:0] in_pitch,
  input  logic signed [IN_W-1:0] in_roll,
  input  side_t                  in_side,
  output logic                   out_vld,
  output logic signed [CW-1:0]   out_cp,
  output logic signed [CW-1:0]   out_sp,
  output logic signed [CW-1:0]   out_cr,
  output logic signed [CW-1:0]   out_sr,
  output side_t                  out_side
);

  logic signed [IN_W-1:0] ang     [2];
  logic signed [AW-1:0]   a_nxt   [2];
  logic        [AW-1:0]   mag_nxt [2];
  logic signed [AW-1:0]   red_nxt [2];

  logic                   m_vld_r;
  logic signed [RW-1:0]   m_a_r   [2];
  side_t                  m_side_r;

  logic signed [RW-1:0]   w_nxt   [2];
  logic                   f_nxt   [2];

  logic                   vld_r   [0:NSTEP];
  side_t                  side_r  [0:NSTEP];
  logic signed [CW-1:0]   cx_r    [0:NSTEP][2];
  logic signed [CW-1:0]   cy_r    [0:NSTEP][2];
  logic signed [RW-1:0]   ca_r    [0:NSTEP][2];
  logic                   flip_r  [0:NSTEP][2];

  logic                   o_vld_r;
  side_t                  o_side_r;
  logic signed [CW-1:0]   oc_r    [2];
  logic signed [CW-1:0]   os_r    [2];

  assign ang[0] = in_pitch;
  assign ang[1] = in_roll;

  // Reduce the Q.30 angle modulo 2*pi, keeping its sign
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a_nxt[l]   = AW'(ang[l]) <<< SH;
      mag_nxt[l] = a_nxt[l][AW-1] ? AW'(-a_nxt[l]) : AW'(a_nxt[l]);
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
        if (mag_nxt[l] >= (AW'(TWO_PI_Q) << k)) begin
          mag_nxt[l] = mag_nxt[l] - (AW'(TWO_PI_Q) << k);
        end
      end
      red_nxt[l] = a_nxt[l][AW-1] ? -$signed(mag_nxt[l]) : $signed(mag_nxt[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= in_vld;
    end
    m_side_r <= in_side;
    for (int l = 0; l < 2; l++) begin
      m_a_r[l] <= red_nxt[l][RW-1:0];
    end
  end

  // Wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      w_nxt[l] = m_a_r[l];
      f_nxt[l] = 1'b0;
      if (w_nxt[l] > PI_Q) begin
        w_nxt[l] = w_nxt[l] - RW'(TWO_PI_Q);
      end else if (w_nxt[l] < -PI_Q) begin
        w_nxt[l] = w_nxt[l] + RW'(TWO_PI_Q);
      end
      if (w_nxt[l] > HALF_PI_Q) begin
        w_nxt[l] = w_nxt[l] - RW'(PI_Q);
        f_nxt[l] = 1'b1;
      end else if (w_nxt[l] < -HALF_PI_Q) begin
        w_nxt[l] = w_nxt[l] + RW'(PI_Q);
        f_nxt[l] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= m_vld_r;
    end
    side_r[0] <= m_side_r;
    for (int l = 0; l < 2; l++) begin
      cx_r[0][l]   <= CW'(KGAIN_Q);
      cy_r[0][l]   <= '0;
      ca_r[0][l]   <= w_nxt[l];
      flip_r[0][l] <= f_nxt[l];
    end
  end

  // Rotation iterations
  for (genvar i = 0; i < NSTEP; i++) begin : g_rot
    localparam logic signed [RW-1:0] ATAN_I = RW'(atan_f(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      side_r[i+1] <= side_r[i];
      for (int l = 0; l < 2; l++) begin
        flip_r[i+1][l] <= flip_r[i][l];
        if (ca_r[i][l] >= 0) begin
          cx_r[i+1][l] <= cx_r[i][l] - (cy_r[i][l] >>> i);
          cy_r[i+1][l] <= cy_r[i][l] + (cx_r[i][l] >>> i);
          ca_r[i+1][l] <= ca_r[i][l] - ATAN_I;
        end else begin
          cx_r[i+1][l] <= cx_r[i][l] + (cy_r[i][l] >>> i);
          cy_r[i+1][l] <= cy_r[i][l] - (cx_r[i][l] >>> i);
          ca_r[i+1][l] <= ca_r[i][l] + ATAN_I;
        end
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else begin
      o_vld_r <= vld_r[NSTEP];
    end
    o_side_r <= side_r[NSTEP];
    for (int l = 0; l < 2; l++) begin
      oc_r[l] <= flip_r[NSTEP][l] ? -cx_r[NSTEP][l] : cx_r[NSTEP][l];
      os_r[l] <= flip_r[NSTEP][l] ? -cy_r[NSTEP][l] : cy_r[NSTEP][l];
    end
  end

  assign out_vld  = o_vld_r;
  assign out_side = o_side_r;
  assign out_cp   = oc_r[0];
  assign out_sp   = os_r[0];
  assign out_cr   = oc_r[1];
  assign out_sr   = os_r[1];

endmodule

[design/thc_tilt.sv]
// Tilt projection: forms the vectoring operands from the field and the angle terms.
module thc_tilt import thc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [CW-1:0] in_cp,
  input  logic signed [CW-1:0] in_sp,
  input  logic signed [CW-1:0] in_cr,
  input  logic signed [CW-1:0] in_sr,
  input  side_t                in_side,
  output logic                 out_vld,
  output logic signed [VW-1:0] out_x,
  output logic signed [VW-1:0] out_y
);

  localparam int P2W = 2 * CW;
  localparam int P1W = SUM_W + CW;
  localparam int P3W = SUM_W + RW;

  // Stage 1: angle products and direct field terms
  logic                   t1_vld_r;
  side_t                  t1_side_r;
  logic signed [P2W-1:0]  t1_ss_r, t1_cs_r;
  logic signed [P1W-1:0]  t1_xc_r, t1_yc_r, t1_zs_r;

  // Stage 2: rounded angle products
  logic                   t2_vld_r;
  side_t                  t2_side_r;
  logic signed [RW-1:0]   t2_ss_r, t2_cs_r;
  logic signed [P1W-1:0]  t2_xc_r, t2_yc_r, t2_zs_r;

  // Stage 3: cross terms
  logic                   t3_vld_r;
  side_t                  t3_side_r;
  logic signed [P3W-1:0]  t3_ys_r, t3_zc_r;
  logic signed [P1W-1:0]  t3_xc_r, t3_yc_r, t3_zs_r;

  // Stage 4: operands
  logic                   t4_vld_r;
  logic signed [VW-1:0]   t4_x_r, t4_y_r;
  logic signed [RND_W-1:0] rs_ss_nxt, rs_cs_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
      t4_vld_r <= 1'b0;
    end else begin
      t1_vld_r <= in_vld;
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
      t4_vld_r <= t3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_side_r <= in_side;
    t1_ss_r   <= in_sr * in_sp;
    t1_cs_r   <= in_cr * in_sp;
    t1_xc_r   <= P1W'(in_side.sx) * P1W'(in_cp);
    t1_yc_r   <= P1W'(in_side.sy) * P1W'(in_cr);
    t1_zs_r   <= P1W'(in_side.sz) * P1W'(in_sr);
  end

  assign rs_ss_nxt = rnd_shift_f(RND_W'(t1_ss_r), QA);
  assign rs_cs_nxt = rnd_shift_f(RND_W'(t1_cs_r), QA);

  always_ff @(posedge clk) begin
    t2_side_r <= t1_side_r;
    t2_ss_r   <= rs_ss_nxt[RW-1:0];
    t2_cs_r   <= rs_cs_nxt[RW-1:0];
    t2_xc_r   <= t1_xc_r;
    t2_yc_r   <= t1_yc_r;
    t2_zs_r   <= t1_zs_r;
  end

  always_ff @(posedge clk) begin
    t3_side_r <= t2_side_r;
    t3_ys_r   <= P3W'(t2_side_r.sy) * P3W'(t2_ss_r);
    t3_zc_r   <= P3W'(t2_side_r.sz) * P3W'(t2_cs_r);
    t3_xc_r   <= t2_xc_r;
    t3_yc_r   <= t2_yc_r;
    t3_zs_r   <= t2_zs_r;
  end

  // Select level or tilt-compensated operands
  always_ff @(posedge clk) begin
    if (t3_side_r.mode) begin
      t4_x_r <= VW'(t3_xc_r) - VW'(t3_ys_r) - VW'(t3_zc_r);
      t4_y_r <= VW'(t3_yc_r) - VW'(t3_zs_r);
    end else begin
      t4_x_r <= VW'(t3_side_r.sx) <<< QA;
      t4_y_r <= VW'(t3_side_r.sy) <<< QA;
    end
  end

  assign out_vld = t4_vld_r;
  assign out_x   = t4_x_r;
  assign out_y   = t4_y_r;

endmodule

[design/thc_vector.sv]
// Pipelined CORDIC vectoring with declination, wrap and output rounding.
module thc_vector import thc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic signed [VW-1:0]   in_x,
  input  logic signed [VW-1:0]   in_y,
  input  logic signed [IN_W-1:0] decl,
  output logic                   out_vld,
  output logic signed [IN_W-1:0] out_heading
);

  logic                    vld_r  [0:NSTEP];
  logic                    zero_r [0:NSTEP];
  logic signed [VW-1:0]    vx_r   [0:NSTEP];
  logic signed [VW-1:0]    vy_r   [0:NSTEP];
  logic signed [ZW-1:0]    vz_r   [0:NSTEP];

  logic signed [HW-1:0]    h_nxt;
  logic                    p1_vld_r;
  logic signed [HW-1:0]    p1_h_r;

  logic signed [RND_W-1:0] r_nxt;
  logic                    p2_vld_r;
  logic signed [IN_W-1:0]  p2_r;

  // Move the vector into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    if (in_x < 0) begin
      vx_r[0] <= -in_x;
      vy_r[0] <= -in_y;
      vz_r[0] <= (in_y >= 0) ? ZW'(PI_Q) : -ZW'(PI_Q);
    end else begin
      vx_r[0] <= in_x;
      vy_r[0] <= in_y;
      vz_r[0] <= '0;
    end
  end

  // Vectoring iterations
  for (genvar i = 0; i < NSTEP; i++) begin : g_vec
    localparam logic signed [ZW-1:0] ATAN_I = ZW'(atan_f(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      zero_r[i+1] <= zero_r[i];
      if (vy_r[i] > 0) begin
        vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] + ATAN_I;
      end else begin
        vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
        vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
        vz_r[i+1] <= vz_r[i] - ATAN_I;
      end
    end
  end

  // Add a positive declination, wrap once, clamp to +-pi
  always_comb begin
    h_nxt = zero_r[NSTEP] ? '0 : HW'(vz_r[NSTEP]);
    if (decl > 0) begin
      h_nxt = h_nxt + (HW'(decl) <<< SH);
      if (h_nxt > PI_Q) begin
        h_nxt = h_nxt - HW'(TWO_PI_Q);
      end else if (h_nxt < -PI_Q) begin
        h_nxt = h_nxt + HW'(TWO_PI_Q);
      end
    end
    if (h_nxt > PI_Q) begin
      h_nxt = HW'(PI_Q);
    end
    if (h_nxt < -PI_Q) begin
      h_nxt = -HW'(PI_Q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= vld_r[NSTEP];
    end
    p1_h_r <= h_nxt;
  end

  // Round to the output angle format and saturate
  always_comb begin
    r_nxt = rnd_shift_f(RND_W'(p1_h_r), SH);
    if (r_nxt > PI_OUT) begin
      r_nxt = RND_W'(PI_OUT);
    end
    if (r_nxt < -PI_OUT) begin
      r_nxt = -RND_W'(PI_OUT);
    end
    if (r_nxt > 32767) begin
      r_nxt = RND_W'(32767);
    end
    if (r_nxt < -32768) begin
      r_nxt = -RND_W'(32768);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_r <= r_nxt[IN_W-1:0];
  end

  assign out_vld     = p2_vld_r;
  assign out_heading = p2_r;

endmodule

[design/tilt_compensated_heading_core.sv]
// Top level: tilt-compensated compass heading core.
//
//   port group  direction  handshake           payload
//   in_         input      start, busy         in_item  (in_t)
//   out_        output     out_strobe          out_item (out_t)
//   cfg_        input      cfg_we              cfg_index, cfg_wdata
//
// One transaction enters per cycle; busy stays low, so start alone accepts.
// The heading path is the two CORDIC pipelines in series with the tilt
// multiplier stages between them; the field divider runs beside them and
// its output is delayed to leave with the heading. Reset is synchronous
// and resets only the valid bits and config registers, gain to 1300.
// The receiver cannot stall: out_strobe marks each result for one cycle.
module tilt_compensated_heading_core import thc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_item,
  output logic                 out_strobe,
  output out_t                 out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IN_W-1:0]      cfg_wdata
);

  logic signed [IN_W-1:0] ofs_x_r, ofs_y_r, ofs_z_r, decl_r;
  logic        [IN_W-1:0] gain_r;

  logic                   accept;
  logic                   s0_vld_r;
  side_t                  s0_side_r;
  logic signed [IN_W-1:0] s0_pitch_r, s0_roll_r;

  logic                   sc_vld;
  logic signed [CW-1:0]   sc_cp, sc_sp, sc_cr, sc_sr;
  side_t                  sc_side;

  logic                   tl_vld;
  logic signed [VW-1:0]   tl_x, tl_y;

  logic                   vc_vld;
  logic signed [IN_W-1:0] vc_heading;

  logic                   dv_vld;
  logic signed [FLD_W-1:0] dv_fx, dv_fy, dv_fz;

  logic                   fd_vld_r [FLD_DLY];
  logic signed [FLD_W-1:0] fd_x_r  [FLD_DLY];
  logic signed [FLD_W-1:0] fd_y_r  [FLD_DLY];
  logic signed [FLD_W-1:0] fd_z_r  [FLD_DLY];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_x_r <= '0;
      ofs_y_r <= '0;
      ofs_z_r <= '0;
      gain_r  <= IN_W'(1300);
      decl_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OFS_X: ofs_x_r <= cfg_wdata;
        CFG_OFS_Y: ofs_y_r <= cfg_wdata;
        CFG_OFS_Z: ofs_z_r <= cfg_wdata;
        CFG_GAIN:  gain_r  <= cfg_wdata;
        CFG_DECL:  decl_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Capture the transaction and apply hard-iron offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
    s0_side_r.mode <= in_item.mode;
    s0_side_r.sx   <= SUM_W'(in_item.raw_x) + SUM_W'(ofs_x_r);
    s0_side_r.sy   <= SUM_W'(in_item.raw_y) + SUM_W'(ofs_y_r);
    s0_side_r.sz   <= SUM_W'(in_item.raw_z) + SUM_W'(ofs_z_r);
    s0_pitch_r     <= in_item.pitch_angle;
    s0_roll_r      <= in_item.roll_angle;
  end

  thc_fld_div u_fld_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (s0_vld_r),
    .in_sx   (s0_side_r.sx),
    .in_sy   (s0_side_r.sy),
    .in_sz   (s0_side_r.sz),
    .gain    (gain_r),
    .out_vld (dv_vld),
    .out_fx  (dv_fx),
    .out_fy  (dv_fy),
    .out_fz  (dv_fz)
  );

  thc_sincos u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s0_vld_r),
    .in_pitch (s0_pitch_r),
    .in_roll  (s0_roll_r),
    .in_side  (s0_side_r),
    .out_vld  (sc_vld),
    .out_cp   (sc_cp),
    .out_sp   (sc_sp),
    .out_cr   (sc_cr),
    .out_sr   (sc_sr),
    .out_side (sc_side)
  );

  thc_tilt u_tilt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sc_vld),
    .in_cp   (sc_cp),
    .in_sp   (sc_sp),
    .in_cr   (sc_cr),
    .in_sr   (sc_sr),
    .in_side (sc_side),
    .out_vld (tl_vld),
    .out_x   (tl_x),
    .out_y   (tl_y)
  );

  thc_vector u_vector (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (tl_vld),
    .in_x        (tl_x),
    .in_y        (tl_y),
    .decl        (decl_r),
    .out_vld     (vc_vld),
    .out_heading (vc_heading)
  );

  // Hold the scaled fields until the heading catches up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < FLD_DLY; d++) begin
        fd_vld_r[d] <= 1'b0;
      end
    end else begin
      fd_vld_r[0] <= dv_vld;
      for (int d = 1; d < FLD_DLY; d++) begin
        fd_vld_r[d] <= fd_vld_r[d-1];
      end
    end
    fd_x_r[0] <= dv_fx;
    fd_y_r[0] <= dv_fy;
    fd_z_r[0] <= dv_fz;
    for (int d = 1; d < FLD_DLY; d++) begin
      fd_x_r[d] <= fd_x_r[d-1];
      fd_y_r[d] <= fd_y_r[d-1];
      fd_z_r[d] <= fd_z_r[d-1];
    end
  end

  assign out_strobe             = vc_vld;
  assign out_item.field_x       = fd_x_r[FLD_DLY-1];
  assign out_item.field_y       = fd_y_r[FLD_DLY-1];
  assign out_item.field_z       = fd_z_r[FLD_DLY-1];
  assign out_item.heading_angle = vc_heading;

  // Field and heading halves of a result leave together
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == fd_vld_r[FLD_DLY-1])
    else $error("field delay line out of step with heading pipeline");

  // Every result traces back to an earlier accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching accepted transaction");

  // Heading stays within +-pi
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.heading_angle <= PI_OUT && out_item.heading_angle >= -PI_OUT))
    else $error("heading outside +-pi");

endmodule
